// File: src/sfd_pkg.sv
// Package for the serial frame deframer: constants, codes and shared types.
// Used by every module of the block; depends on nothing.
`timescale 1ns / 1ps

package sfd_pkg;

  // Number of equal bytes that make up a start marker.
  localparam int MARKER_LENGTH = 8;
  localparam int MCW           = $clog2(MARKER_LENGTH);

  // Header: 32-bit length then 32-bit checksum, both little endian.
  localparam int HDR_BYTES = 8;
  localparam int HCW       = $clog2(HDR_BYTES);

  localparam logic [15:0] MAX_LENGTH_RESET    = 16'd8192;
  localparam logic [31:0] CHECKSUM_SEED_RESET = 32'h5555_5555;

  // Configuration register indexes.
  localparam logic CFG_MAX_LENGTH    = 1'b0;
  localparam logic CFG_CHECKSUM_SEED = 1'b1;

  typedef enum logic [1:0] {
    PH_HUNT    = 2'd0,
    PH_HEADER  = 2'd1,
    PH_PAYLOAD = 2'd2
  } phase_t;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_CHECKSUM = 2'd1,
    ST_LENGTH   = 2'd2,
    ST_CMD_ZERO = 2'd3
  } status_t;

  typedef struct packed {
    logic [7:0]  data_byte;
    logic        data_valid;
    logic        frame_end;
    status_t     status;
    logic [6:0]  command;
    logic [15:0] payload_len;
  } result_t;

endpackage

// File: src/sfd_parser.sv
// Frame parser: configuration registers, marker hunt, header capture and
// payload checksum. Produces at most one result per accepted byte. Uses sfd_pkg.
`timescale 1ns / 1ps

module sfd_parser (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             cfg_we,
  input  logic             cfg_index,
  input  logic [31:0]      cfg_data,
  input  logic             step,
  input  logic [7:0]       rx_byte,
  output logic             res_valid,
  output sfd_pkg::result_t res
);
  import sfd_pkg::*;

  logic [15:0]    max_length_r;
  logic [31:0]    checksum_seed_r;
  phase_t         phase_r, phase_nxt;
  logic [7:0]     marker_byte_r, marker_byte_nxt;
  logic [MCW-1:0] marker_count_r, marker_count_nxt;
  logic [HCW-1:0] header_count_r, header_count_nxt;
  logic [31:0]    length_r, length_nxt;
  logic [31:0]    expected_r, expected_nxt;
  logic [31:0]    running_r, running_nxt;
  logic [15:0]    bytes_left_r, bytes_left_nxt;
  logic [4:0]     lane_ofs;

  assign lane_ofs = {header_count_r[1:0], 3'b000};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_length_r    <= MAX_LENGTH_RESET;
      checksum_seed_r <= CHECKSUM_SEED_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_MAX_LENGTH:    max_length_r    <= cfg_data[15:0];
        CFG_CHECKSUM_SEED: checksum_seed_r <= cfg_data;
        default:           ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r        <= PH_HUNT;
      marker_byte_r  <= '0;
      marker_count_r <= '0;
      header_count_r <= '0;
      length_r       <= '0;
      expected_r     <= '0;
      running_r      <= '0;
      bytes_left_r   <= '0;
    end else if (step) begin
      phase_r        <= phase_nxt;
      marker_byte_r  <= marker_byte_nxt;
      marker_count_r <= marker_count_nxt;
      header_count_r <= header_count_nxt;
      length_r       <= length_nxt;
      expected_r     <= expected_nxt;
      running_r      <= running_nxt;
      bytes_left_r   <= bytes_left_nxt;
    end
  end

  always_comb begin
    phase_nxt        = phase_r;
    marker_byte_nxt  = marker_byte_r;
    marker_count_nxt = marker_count_r;
    header_count_nxt = header_count_r;
    length_nxt       = length_r;
    expected_nxt     = expected_r;
    running_nxt      = running_r;
    bytes_left_nxt   = bytes_left_r;
    res_valid        = 1'b0;
    res              = '0;
    res.status       = ST_OK;
    res.command      = marker_byte_r[6:0];
    res.payload_len  = (|length_r[31:16]) ? 16'hFFFF : length_r[15:0];

    case (phase_r)
      PH_HEADER: begin
        if (!header_count_r[HCW-1]) begin
          length_nxt[lane_ofs +: 8] = rx_byte;
        end else begin
          expected_nxt[lane_ofs +: 8] = rx_byte;
        end
        header_count_nxt = header_count_r + 1'b1;
        if (header_count_r == HCW'(HDR_BYTES - 1)) begin
          running_nxt = checksum_seed_r;
          if (marker_byte_r[6:0] == 7'd0) begin
            res_valid        = 1'b1;
            res.frame_end    = 1'b1;
            res.status       = ST_CMD_ZERO;
            phase_nxt        = PH_HUNT;
            marker_count_nxt = '0;
          end else if (length_r > {16'd0, max_length_r}) begin
            res_valid        = 1'b1;
            res.frame_end    = 1'b1;
            res.status       = ST_LENGTH;
            phase_nxt        = PH_HUNT;
            marker_count_nxt = '0;
          end else if (length_r == 32'd0) begin
            res_valid        = 1'b1;
            res.frame_end    = 1'b1;
            res.status       = (checksum_seed_r == expected_nxt) ? ST_OK : ST_CHECKSUM;
            phase_nxt        = PH_HUNT;
            marker_count_nxt = '0;
          end else begin
            // Length is at most max_length here, so it fits in 16 bits.
            bytes_left_nxt = length_r[15:0];
            phase_nxt      = PH_PAYLOAD;
          end
        end
      end

      PH_PAYLOAD: begin
        running_nxt    = running_r ^ {24'd0, rx_byte};
        bytes_left_nxt = (bytes_left_r == 16'd0) ? 16'd0 : bytes_left_r - 16'd1;
        res_valid      = 1'b1;
        res.data_byte  = rx_byte;
        res.data_valid = 1'b1;
        if (bytes_left_nxt == 16'd0) begin
          res.frame_end    = 1'b1;
          res.status       = (running_nxt == expected_r) ? ST_OK : ST_CHECKSUM;
          phase_nxt        = PH_HUNT;
          marker_count_nxt = '0;
          header_count_nxt = '0;
        end
      end

      default: begin
        phase_nxt = PH_HUNT;
        if (marker_count_r == '0) begin
          if (rx_byte[7]) begin
            marker_byte_nxt  = rx_byte;
            marker_count_nxt = MCW'(1);
          end
        end else if (rx_byte != marker_byte_r) begin
          // A mismatch restarts the hunt and the byte does not seed a new marker.
          marker_byte_nxt  = rx_byte;
          marker_count_nxt = '0;
        end else if (marker_count_r == MCW'(MARKER_LENGTH - 1)) begin
          marker_count_nxt = '0;
          header_count_nxt = '0;
          length_nxt       = '0;
          expected_nxt     = '0;
          phase_nxt        = PH_HEADER;
        end else begin
          marker_count_nxt = marker_count_r + 1'b1;
        end
      end
    endcase
  end

endmodule

// File: src/sfd_out_stage.sv
// Result register of the deframer, with valid/ready toward the consumer.
// Uses sfd_pkg for the result type.
`timescale 1ns / 1ps

module sfd_out_stage (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             load,
  input  sfd_pkg::result_t load_res,
  input  logic             out_ready,
  output logic             out_valid,
  output logic             can_load,
  output sfd_pkg::result_t res
);
  import sfd_pkg::*;

  logic    valid_r;
  result_t res_r;

  assign can_load  = !valid_r || out_ready;
  assign out_valid = valid_r;
  assign res       = res_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (load) begin
      valid_r <= 1'b1;
    end else if (out_ready) begin
      valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      res_r <= load_res;
    end
  end

endmodule

// File: src/serial_frame_deframer.sv
// Top level of the serial frame deframer.
// Instantiates sfd_parser and sfd_out_stage; uses sfd_pkg.
`timescale 1ns / 1ps

// The deframer takes one received byte per transfer and sustains one byte
// per clock cycle: the parser's next state and result are formed in the
// same cycle the byte is accepted, and the result lands in a single output
// register. A new byte is accepted whenever that register is empty or is
// being drained in the same cycle, so a transfer on each side can happen
// in every cycle; a byte that gives no result (marker and header bytes)
// never waits on the consumer unless the output register is held full.
// Each frame opens with a marker of eight equal bytes of value 128 or more,
// followed by an eight-byte header: a little-endian 32-bit payload length
// and a little-endian 32-bit expected checksum. Payload bytes come out one
// per result; the result carrying the last payload byte, or the one issued
// right after the header when no payload is taken, has frame_end set and
// a valid status. The checksum is the seed XORed with every payload byte.
// Configuration writes (max_length at index 0, checksum_seed at index 1)
// take effect at the clock edge where cfg_we is high.

module serial_frame_deframer (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [31:0] cfg_data,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  in_rx_byte,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [7:0]  out_data_byte,
  output logic        out_data_valid,
  output logic        out_frame_end,
  output logic [1:0]  out_status,
  output logic [6:0]  out_command,
  output logic [15:0] out_payload_len
);
  import sfd_pkg::*;

  logic    step;
  logic    res_valid;
  logic    can_load;
  result_t res;
  result_t out_res;

  // A byte transfer happens when the output register can take a result.
  assign in_ready = can_load;
  assign step     = in_valid && in_ready;

  sfd_parser u_parser (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .step      (step),
    .rx_byte   (in_rx_byte),
    .res_valid (res_valid),
    .res       (res)
  );

  sfd_out_stage u_out (
    .clk       (clk),
    .rst_n     (rst_n),
    .load      (step && res_valid),
    .load_res  (res),
    .out_ready (out_ready),
    .out_valid (out_valid),
    .can_load  (can_load),
    .res       (out_res)
  );

  assign out_data_byte   = out_res.data_byte;
  assign out_data_valid  = out_res.data_valid;
  assign out_frame_end   = out_res.frame_end;
  assign out_status      = out_res.status;
  assign out_command     = out_res.command;
  assign out_payload_len = out_res.payload_len;

  // A result without a payload byte only ever closes a frame.
  a_no_data_closes: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_data_valid) |-> out_frame_end)
    else $error("result without payload byte does not close a frame");

  // Status is only meaningful on the closing result and is zero otherwise.
  a_status_only_at_end: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_frame_end) |-> (out_status == ST_OK))
    else $error("nonzero status on a result that does not close a frame");

  // A held result blocks new bytes, so no result can be overwritten.
  a_held_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |-> !in_ready)
    else $error("byte accepted while the output register is held");

endmodule

// File: sim/tb_top.sv
// Self-checking testbench for serial_frame_deframer: directed frames, config
// extremes, a long consumer stall and random frame traffic against a predictor.
// Depends on sfd_pkg and serial_frame_deframer from the RTL.
`timescale 1ns / 1ps

module tb_top;
  import sfd_pkg::*;

  // The longest legal quiet stretch is the consumer hold below plus short
  // random gaps, so anything far past that is a hang.
  localparam int unsigned HOLD_CYCLES  = 300;
  localparam int unsigned STALL_LIMIT  = 4000;
  localparam int unsigned RANDOM_BYTES = 1300;
  localparam int unsigned IDLE_PCT     = 13;

  logic        clk;
  logic        rst_n          = 1'b0;
  logic        cfg_we         = 1'b0;
  logic        cfg_index      = CFG_MAX_LENGTH;
  logic [31:0] cfg_data       = '0;
  logic        in_valid       = 1'b0;
  logic        in_ready;
  logic [7:0]  in_rx_byte     = '0;
  logic        out_valid;
  logic        out_ready      = 1'b0;
  logic [7:0]  out_data_byte;
  logic        out_data_valid;
  logic        out_frame_end;
  logic [1:0]  out_status;
  logic [6:0]  out_command;
  logic [15:0] out_payload_len;

  serial_frame_deframer u_top (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_we          (cfg_we),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_rx_byte      (in_rx_byte),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_data_byte   (out_data_byte),
    .out_data_valid  (out_data_valid),
    .out_frame_end   (out_frame_end),
    .out_status      (out_status),
    .out_command     (out_command),
    .out_payload_len (out_payload_len)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Shared control between the stimulus, the consumer and the checker.
  bit          gaps_on      = 1'b1;
  bit          hold_request = 1'b0;
  int unsigned hold_left    = 0;
  int unsigned quiet_cycles = 0;
  int unsigned frame_bytes  = 0;
  int unsigned errors       = 0;

  // Deframer model state and its copy of the two registers.
  phase_t      ph;
  logic [7:0]  mk_byte;
  int unsigned mk_count;
  logic [2:0]  hdr_count;
  logic [31:0] len_word;
  logic [31:0] sum_expected;
  logic [31:0] sum_running;
  logic [31:0] bytes_left;
  logic [15:0] max_len_cfg;
  logic [31:0] seed_cfg;

  // Results the deframer owes us, oldest first.
  result_t expected_results[$];
  result_t next_expected;

  // Every result of a frame carries the command and the saturated length.
  function automatic result_t frame_result(logic [7:0] d, logic dv, logic fe,
                                           status_t st);
    result_t r;
    r.data_byte   = d;
    r.data_valid  = dv;
    r.frame_end   = fe;
    r.status      = st;
    r.command     = mk_byte[6:0];
    r.payload_len = (len_word > 32'h0000_FFFF) ? 16'hFFFF : len_word[15:0];
    return r;
  endfunction

  // Closing a frame always sends the hunt back to a fresh start.
  task automatic close_frame(input logic [7:0] d, input logic dv, input status_t st);
    ph        = PH_HUNT;
    mk_count  = 0;
    hdr_count = '0;
    expected_results.push_back(frame_result(d, dv, 1'b1, st));
  endtask

  // Advances the model by one accepted byte and queues any result it causes.
  task automatic deframe_byte(input logic [7:0] b);
    logic [2:0] pos;
    case (ph)
      PH_HEADER: begin
        pos = hdr_count;
        if (pos < 4) begin
          len_word[8*pos[1:0] +: 8] = b;
        end else begin
          sum_expected[8*pos[1:0] +: 8] = b;
        end
        hdr_count = pos + 3'd1;
        if (pos == HDR_BYTES - 1) begin
          sum_running = seed_cfg;
          // Command zero wins over every other check, then the length limit.
          if (mk_byte[6:0] == 7'd0) begin
            close_frame(8'd0, 1'b0, ST_CMD_ZERO);
          end else if (len_word > {16'd0, max_len_cfg}) begin
            close_frame(8'd0, 1'b0, ST_LENGTH);
          end else if (len_word == 32'd0) begin
            close_frame(8'd0, 1'b0,
                        (sum_running == sum_expected) ? ST_OK : ST_CHECKSUM);
          end else begin
            bytes_left = len_word;
            ph         = PH_PAYLOAD;
          end
        end
      end
      PH_PAYLOAD: begin
        sum_running = sum_running ^ {24'd0, b};
        if (bytes_left != 0) bytes_left = bytes_left - 1;
        if (bytes_left == 0) begin
          close_frame(b, 1'b1, (sum_running == sum_expected) ? ST_OK : ST_CHECKSUM);
        end else begin
          expected_results.push_back(frame_result(b, 1'b1, 1'b0, ST_OK));
        end
      end
      default: begin
        // Hunting. A byte that breaks a marker is dropped and only remembered,
        // so it cannot begin the next marker by itself.
        ph = PH_HUNT;
        if (mk_count == 0) begin
          if (b[7]) begin
            mk_byte  = b;
            mk_count = 1;
          end
        end else if (b != mk_byte) begin
          mk_byte  = b;
          mk_count = 0;
        end else begin
          mk_count++;
          if (mk_count >= MARKER_LENGTH) begin
            mk_count     = 0;
            hdr_count    = '0;
            len_word     = '0;
            sum_expected = '0;
            ph           = PH_HEADER;
          end
        end
      end
    endcase
  endtask

  // Offers one byte, with random idle cycles ahead of it, and holds it
  // steady until the transfer happens.
  task automatic send_byte(input logic [7:0] b);
    while (gaps_on && $urandom_range(99) < IDLE_PCT) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid   <= 1'b1;
    in_rx_byte <= b;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    deframe_byte(b);
  endtask

  // Sends marker, header and payload. The header checksum is the correct one
  // XORed with sum_flip, so any nonzero flip makes a checksum error in an
  // accepted frame. No payload follows a header that the block will reject.
  task automatic send_frame(input logic [7:0] marker, input logic [31:0] length,
                            input logic [31:0] sum_flip);
    logic [7:0]  payload[$];
    logic [7:0]  fold;
    logic [7:0]  pb;
    logic [31:0] sum;
    int unsigned n;
    n    = (marker[6:0] == 7'd0 || length > {16'd0, max_len_cfg}) ? 0 : length;
    fold = '0;
    repeat (n) begin
      pb   = 8'($urandom_range(255));
      fold = fold ^ pb;
      payload.push_back(pb);
    end
    sum = seed_cfg ^ {24'd0, fold} ^ sum_flip;
    repeat (MARKER_LENGTH) send_byte(marker);
    for (int i = 0; i < 4; i++) send_byte(length[8*i +: 8]);
    for (int i = 0; i < 4; i++) send_byte(sum[8*i +: 8]);
    foreach (payload[i]) send_byte(payload[i]);
    frame_bytes += MARKER_LENGTH + HDR_BYTES + n;
  endtask

  // A byte below 128 always clears a partial marker while hunting.
  task automatic send_sync();
    send_byte(8'($urandom_range(127)));
  endtask

  // Registers are only written with nothing owed and the input quiet; the few
  // extra cycles cover a header byte that was accepted but gave no result.
  task automatic write_config(input logic [15:0] max_len, input logic [31:0] seed);
    in_valid <= 1'b0;
    @(posedge clk);
    while (expected_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= CFG_MAX_LENGTH;
    cfg_data  <= {16'd0, max_len};
    @(posedge clk);
    max_len_cfg = max_len;
    cfg_index <= CFG_CHECKSUM_SEED;
    cfg_data  <= seed;
    @(posedge clk);
    seed_cfg = seed;
    cfg_we <= 1'b0;
  endtask

  // Low bytes, command zero, zero-length frames both ways, checksum errors,
  // lengths beyond the limit and beyond 16 bits, and a broken marker whose
  // breaking byte must not count toward the next marker.
  task automatic test_special_cases();
    send_byte(8'h00);
    send_byte(8'h7F);
    send_frame(8'hFF, 32'd3, 32'd0);
    send_frame(8'h80, 32'd5, 32'd0);
    send_frame(8'h80, 32'hFFFF_FFFF, 32'd0);
    send_frame(8'h81, 32'd0, 32'd0);
    send_frame(8'h81, 32'd0, 32'h8000_0000);
    send_frame(8'hC3, 32'd2, 32'h0000_0100);
    send_frame(8'h85, 32'h0001_0000, 32'd0);
    send_frame(8'h85, 32'hFFFF_FFFF, 32'd0);
    repeat (3) send_byte(8'h90);
    send_byte(8'hA0);
    send_frame(8'hA0, 32'd1, 32'd0);
  endtask

  // Limits at zero, just around a small value and at the top, with seeds at
  // both ends. At the top limit a moderate frame passes and a length just
  // past 16 bits is still refused.
  task automatic test_config_extremes();
    write_config(16'd0, 32'd0);
    send_frame(8'h8A, 32'd0, 32'd0);
    send_frame(8'h8A, 32'd1, 32'd0);
    write_config(16'd5, 32'hFFFF_FFFF);
    send_frame(8'hB1, 32'd5, 32'd0);
    send_frame(8'hB1, 32'd6, 32'd0);
    send_frame(8'hB1, 32'd0, 32'd0);
    write_config(16'hFFFF, $urandom);
    send_frame(8'hEE, 32'd100, 32'd0);
    send_frame(8'hEE, 32'h0001_0000, 32'd0);
  endtask

  // The consumer stops for a long stretch while the producer keeps offering a
  // frame, so the output register fills and in_ready has to drop.
  task automatic test_backpressure();
    gaps_on = 1'b0;
    hold_request <= 1'b1;
    @(posedge clk);
    while (hold_left == 0) @(posedge clk);
    hold_request <= 1'b0;
    send_sync();
    send_frame(8'h9A, 32'd40, 32'd0);
    gaps_on = 1'b1;
  endtask

  // Mostly well-formed frames with random content, the rest noise and broken
  // markers, over four register settings; one phase runs without idle cycles.
  task automatic test_random_traffic();
    logic [7:0]  marker;
    logic [31:0] length;
    logic [31:0] flip;
    int unsigned target;
    for (int phase_no = 0; phase_no < 4; phase_no++) begin
      case (phase_no)
        0:       write_config(16'($urandom_range(8, 40)), $urandom);
        1:       write_config(16'hFFFF, 32'd0);
        2:       write_config(16'($urandom_range(0, 65535)), $urandom);
        default: write_config(MAX_LENGTH_RESET, CHECKSUM_SEED_RESET);
      endcase
      gaps_on = (phase_no != 1);
      target  = frame_bytes + RANDOM_BYTES / 4;
      while (frame_bytes < target) begin
        if ($urandom_range(99) < 15) begin
          if ($urandom_range(1) == 1) begin
            repeat ($urandom_range(1, 6)) send_byte(8'($urandom_range(255)));
          end else begin
            marker = 8'($urandom_range(128, 255));
            repeat ($urandom_range(1, 7)) send_byte(marker);
            send_byte(marker ^ 8'($urandom_range(1, 255)));
          end
        end else begin
          marker = ($urandom_range(15) == 0) ? 8'h80 : 8'($urandom_range(129, 255));
          if ($urandom_range(9) == 0) begin
            length = ($urandom_range(1) == 1) ? ($urandom | 32'h0001_0000)
                                              : {16'd0, max_len_cfg} + 1 + $urandom_range(3);
          end else begin
            length = $urandom_range(0, 24);
          end
          flip = ($urandom_range(3) == 0) ? (32'd1 << $urandom_range(31)) : 32'd0;
          send_sync();
          send_frame(marker, length, flip);
        end
      end
    end
    gaps_on = 1'b1;
  endtask

  // Consumer: random stalls, plus the long hold asked for by the
  // backpressure test, counted down here.
  always @(posedge clk) begin : consumer
    int unsigned next_hold;
    next_hold = (hold_left != 0) ? hold_left - 1 : (hold_request ? HOLD_CYCLES : 0);
    hold_left <= next_hold;
    out_ready <= (next_hold == 0) && !(gaps_on && $urandom_range(99) < IDLE_PCT);
  end

  task automatic compare_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
    if (want !== got) begin
      $error("%s mismatch: expected %0h, got %0h", name, want, got);
      errors++;
    end
  endtask

  // Every result transfer is checked against the oldest expectation.
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      if (expected_results.size() == 0) begin
        $error("result with none expected: data_byte %0h frame_end %0b",
               out_data_byte, out_frame_end);
        errors++;
      end else begin
        next_expected = expected_results.pop_front();
        compare_field("data_byte", next_expected.data_byte, out_data_byte);
        compare_field("data_valid", next_expected.data_valid, out_data_valid);
        compare_field("frame_end", next_expected.frame_end, out_frame_end);
        compare_field("status", next_expected.status, out_status);
        compare_field("command", next_expected.command, out_command);
        compare_field("payload_len", next_expected.payload_len, out_payload_len);
      end
    end
  end

  // Watchdog: any transfer or register write counts as progress.
  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready) || cfg_we) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    wait (quiet_cycles >= STALL_LIMIT);
    $display("TB_ERROR");
    $finish;
  end

  initial begin
    ph           = PH_HUNT;
    mk_byte      = '0;
    mk_count     = 0;
    hdr_count    = '0;
    len_word     = '0;
    sum_expected = '0;
    sum_running  = '0;
    bytes_left   = '0;
    max_len_cfg  = MAX_LENGTH_RESET;
    seed_cfg     = CHECKSUM_SEED_RESET;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_special_cases();
    test_config_extremes();
    test_backpressure();
    test_random_traffic();

    // Drain what is still owed, then give the block a few cycles to show any
    // stray result.
    in_valid <= 1'b0;
    @(posedge clk);
    while (expected_results.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (errors == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

// File: serial_frame_deframer.f
src/sfd_pkg.sv
src/sfd_parser.sv
src/sfd_out_stage.sv
src/serial_frame_deframer.sv
sim/tb_top.sv
